[rtl/core/plt_pkg.sv]
`timescale 1ns / 1ps

package plt_pkg;

  // Fixed port widths of the command and result beats
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 6;

  // Defaults for the top-level parameters
  localparam int unsigned CAPACITY_DEF  = 32;
  localparam int unsigned KEY_BITS_DEF  = 64;
  localparam int unsigned DATA_BITS_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_UPDATE = 3'd4,
    CMD_FIND   = 3'd5
  } cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the input beat, clear the result
    logic rd;         // read one entry into the read register
    logic wr_shift;   // write the read register at the pointer
    logic wr_new;     // write the captured key and data
    logic ptr_init;
    logic ptr_step;
    logic cnt_clear;
    logic cnt_inc;
    logic cnt_dec;
    logic set_ok;
    logic set_read;   // take key and data from the read register
    logic set_found;  // record the pointer as the match position
    logic out_load;   // move the result into the output register
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic legal;  // the command may change or read the list
    logic more;   // the walk has another entry to visit
    logic match;  // the read register holds the wanted key
  } dp_stat_t;

endpackage

[rtl/core/plt_ctrl.sv]
`timescale 1ns / 1ps

module plt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  plt_pkg::dp_stat_t  stat_i,
  output plt_pkg::dp_ctrl_t  ctrl_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_FETCH,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    ctrl_o      = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FINISH;
        case (stat_i.cmd)
          plt_pkg::CMD_CLEAR: begin
            ctrl_o.cnt_clear = 1'b1;
            ctrl_o.set_ok    = 1'b1;
          end
          plt_pkg::CMD_INSERT, plt_pkg::CMD_DELETE: begin
            if (stat_i.legal) begin
              ctrl_o.ptr_init = 1'b1;
              state_d         = ST_SHIFT_RD;
            end
          end
          plt_pkg::CMD_READ: begin
            if (stat_i.legal) begin
              ctrl_o.rd = 1'b1;
              state_d   = ST_FETCH;
            end
          end
          plt_pkg::CMD_UPDATE: begin
            if (stat_i.legal) begin
              ctrl_o.wr_new = 1'b1;
              ctrl_o.set_ok = 1'b1;
            end
          end
          plt_pkg::CMD_FIND: begin
            ctrl_o.set_ok   = 1'b1;
            ctrl_o.ptr_init = 1'b1;
            state_d         = ST_SCAN_RD;
          end
          default: ;
        endcase
      end
      ST_SHIFT_RD: begin
        if (stat_i.more) begin
          ctrl_o.rd = 1'b1;
          state_d   = ST_SHIFT_WR;
        end else if (stat_i.cmd == plt_pkg::CMD_INSERT) begin
          state_d = ST_PUT;
        end else begin
          ctrl_o.cnt_dec = 1'b1;
          ctrl_o.set_ok  = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_SHIFT_WR: begin
        ctrl_o.wr_shift = 1'b1;
        ctrl_o.ptr_step = 1'b1;
        state_d         = ST_SHIFT_RD;
      end
      ST_PUT: begin
        ctrl_o.wr_new  = 1'b1;
        ctrl_o.cnt_inc = 1'b1;
        ctrl_o.set_ok  = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FETCH: begin
        ctrl_o.set_read = 1'b1;
        ctrl_o.set_ok   = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_SCAN_RD: begin
        if (stat_i.more) begin
          ctrl_o.rd = 1'b1;
          state_d   = ST_SCAN_CMP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCAN_CMP: begin
        if (stat_i.match) begin
          ctrl_o.set_found = 1'b1;
          state_d          = ST_FINISH;
        end else begin
          ctrl_o.ptr_step = 1'b1;
          state_d         = ST_SCAN_RD;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/plt_datapath.sv]
`timescale 1ns / 1ps

module plt_datapath #(
  parameter int unsigned CAPACITY  = plt_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS  = plt_pkg::KEY_BITS_DEF,
  parameter int unsigned DATA_BITS = plt_pkg::DATA_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [plt_pkg::CMD_W-1:0]   command_i,
  input  logic [plt_pkg::POS_W-1:0]   position_i,
  input  logic                        append_i,
  input  logic [plt_pkg::KEY_W-1:0]   item_key_i,
  input  logic [plt_pkg::DATA_W-1:0]  item_data_i,
  input  plt_pkg::dp_ctrl_t           ctrl_i,
  output plt_pkg::dp_stat_t           stat_o,
  output logic                        ok_o,
  output logic                        found_o,
  output logic [plt_pkg::POS_W-1:0]   found_position_o,
  output logic [plt_pkg::KEY_W-1:0]   read_key_o,
  output logic [plt_pkg::DATA_W-1:0]  read_data_o,
  output logic [plt_pkg::CNT_W-1:0]   entry_count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = (CW > plt_pkg::POS_W) ? CW : plt_pkg::POS_W;
  localparam int unsigned EW = KEY_BITS + DATA_BITS;

  logic [EW-1:0] mem_q [CAPACITY];
  logic [EW-1:0] rd_q;

  plt_pkg::cmd_e           cmd_q;
  logic [plt_pkg::POS_W-1:0] pos_q;
  logic                    app_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [DATA_BITS-1:0]    data_q;

  logic [CW-1:0] cnt_q;
  logic [PW-1:0] ptr_q;

  logic [PW-1:0] pos_x, cnt_x, tgt, ptr_dn, ptr_up;
  logic [PW-1:0] rd_sel, wr_sel;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  // result of the item at work
  logic                       ok_q, found_q;
  logic [plt_pkg::POS_W-1:0]  fpos_q;
  logic [plt_pkg::KEY_W-1:0]  rkey_q;
  logic [plt_pkg::DATA_W-1:0] rdata_q;

  // output register
  logic                       ok_oq, found_oq;
  logic [plt_pkg::POS_W-1:0]  fpos_oq;
  logic [plt_pkg::KEY_W-1:0]  rkey_oq;
  logic [plt_pkg::DATA_W-1:0] rdata_oq;
  logic [plt_pkg::CNT_W-1:0]  cnt_oq;

  assign pos_x  = PW'(pos_q);
  assign cnt_x  = PW'(cnt_q);
  assign tgt    = app_q ? cnt_x : pos_x;
  assign ptr_dn = ptr_q - PW'(1);
  assign ptr_up = ptr_q + PW'(1);

  always_comb begin
    stat_o.cmd   = cmd_q;
    stat_o.match = (rd_q[EW-1:DATA_BITS] == key_q);
    stat_o.legal = 1'b0;
    stat_o.more  = 1'b0;
    rd_sel       = pos_x;
    case (cmd_q)
      plt_pkg::CMD_INSERT: begin
        stat_o.legal = (cnt_q < CW'(CAPACITY)) && (tgt <= cnt_x);
        stat_o.more  = (ptr_q > tgt);
        rd_sel       = ptr_dn;
      end
      plt_pkg::CMD_DELETE: begin
        stat_o.legal = (pos_x < cnt_x);
        stat_o.more  = (ptr_up < cnt_x);
        rd_sel       = ptr_up;
      end
      plt_pkg::CMD_READ, plt_pkg::CMD_UPDATE: begin
        stat_o.legal = (pos_x < cnt_x);
      end
      plt_pkg::CMD_FIND: begin
        stat_o.legal = 1'b1;
        stat_o.more  = (ptr_q < cnt_x);
        rd_sel       = ptr_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = ctrl_i.wr_shift || ctrl_i.wr_new;
    wr_data = rd_q;
    wr_sel  = ptr_q;
    if (ctrl_i.wr_new) begin
      wr_data = {key_q, data_q};
      wr_sel  = (cmd_q == plt_pkg::CMD_INSERT) ? tgt : pos_x;
    end
  end

  assign rd_addr = rd_sel[IW-1:0];
  assign wr_addr = wr_sel[IW-1:0];

  // entry storage: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.cnt_clear) begin
      cnt_q <= '0;
    end else if (ctrl_i.cnt_inc) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (ctrl_i.cnt_dec) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= plt_pkg::cmd_e'(command_i);
      pos_q  <= position_i;
      app_q  <= append_i;
      key_q  <= KEY_BITS'(item_key_i);
      data_q <= DATA_BITS'(item_data_i);
    end
    if (ctrl_i.ptr_init) begin
      case (cmd_q)
        plt_pkg::CMD_INSERT: ptr_q <= cnt_x;
        plt_pkg::CMD_DELETE: ptr_q <= pos_x;
        default:             ptr_q <= '0;
      endcase
    end else if (ctrl_i.ptr_step) begin
      ptr_q <= (cmd_q == plt_pkg::CMD_INSERT) ? ptr_dn : ptr_up;
    end
    if (ctrl_i.load) begin
      ok_q    <= 1'b0;
      found_q <= 1'b0;
      fpos_q  <= '0;
      rkey_q  <= '0;
      rdata_q <= '0;
    end else begin
      if (ctrl_i.set_ok) begin
        ok_q <= 1'b1;
      end
      if (ctrl_i.set_found) begin
        found_q <= 1'b1;
        fpos_q  <= ptr_q[plt_pkg::POS_W-1:0];
      end
      if (ctrl_i.set_read) begin
        rkey_q  <= plt_pkg::KEY_W'(rd_q[EW-1:DATA_BITS]);
        rdata_q <= plt_pkg::DATA_W'(rd_q[DATA_BITS-1:0]);
      end
    end
    if (ctrl_i.out_load) begin
      ok_oq    <= ok_q;
      found_oq <= found_q;
      fpos_oq  <= fpos_q;
      rkey_oq  <= rkey_q;
      rdata_oq <= rdata_q;
      cnt_oq   <= plt_pkg::CNT_W'(cnt_q);
    end
  end

  assign ok_o             = ok_oq;
  assign found_o          = found_oq;
  assign found_position_o = fpos_oq;
  assign read_key_o       = rkey_oq;
  assign read_data_o      = rdata_oq;
  assign entry_count_o    = cnt_oq;

endmodule

[rtl/core/positional_list_table.sv]
`timescale 1ns / 1ps
// Channel | Handshake                  | Beat contents
// --------+----------------------------+-------------------------------------------------
// command | in_valid_i / in_ready_o    | command, position, append, item_key, item_data
// result  | out_valid_o / out_ready_i  | ok, found, found_position, read_key, read_data,
//         |                            | entry_count
//
// One command is worked at a time; the cost is set by the entry memory and its registered
// read port, which moves or visits one entry at a time (read, then write or compare).
// Clear, update, read and failed commands walk no entries. Insert moves the entries from
// the target position to count - 1 up by one, the target being count on an append;
// delete moves the entries above position down by one; find visits entries from the
// front until a match or the end of the list. The next command is taken in the cycle
// after the result is loaded, even while that result still waits for out_ready_i.
// Reset clears the entry count and the handshake state only; no clearing pass.
// A stalled result holds in the output register and blocks only the next finish.

module positional_list_table #(
  parameter int unsigned CAPACITY  = plt_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS  = plt_pkg::KEY_BITS_DEF,
  parameter int unsigned DATA_BITS = plt_pkg::DATA_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [plt_pkg::CMD_W-1:0]   command_i,
  input  logic [plt_pkg::POS_W-1:0]   position_i,
  input  logic                        append_i,
  input  logic [plt_pkg::KEY_W-1:0]   item_key_i,
  input  logic [plt_pkg::DATA_W-1:0]  item_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic                        found_o,
  output logic [plt_pkg::POS_W-1:0]   found_position_o,
  output logic [plt_pkg::KEY_W-1:0]   read_key_o,
  output logic [plt_pkg::DATA_W-1:0]  read_data_o,
  output logic [plt_pkg::CNT_W-1:0]   entry_count_o
);

  // Commands from the sequencer and status back from the entry datapath
  plt_pkg::dp_ctrl_t ctrl;
  plt_pkg::dp_stat_t stat;

  // Sequencer: decode, walk the entries for shifts and key search, hand off the result
  plt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Datapath: entry memory, count, walk pointer, result and output registers
  plt_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .command_i        (command_i),
    .position_i       (position_i),
    .append_i         (append_i),
    .item_key_i       (item_key_i),
    .item_data_i      (item_data_i),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .ok_o             (ok_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .read_key_o       (read_key_o),
    .read_data_o      (read_data_o),
    .entry_count_o    (entry_count_o)
  );

endmodule

[tb/sv/plt_list_checker.sv]
`timescale 1ns / 1ps

module plt_list_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [plt_pkg::CMD_W-1:0]   command_i,
  input  logic [plt_pkg::POS_W-1:0]   position_i,
  input  logic                        append_i,
  input  logic [plt_pkg::KEY_W-1:0]   item_key_i,
  input  logic [plt_pkg::DATA_W-1:0]  item_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        ok_i,
  input  logic                        found_i,
  input  logic [plt_pkg::POS_W-1:0]   found_position_i,
  input  logic [plt_pkg::KEY_W-1:0]   read_key_i,
  input  logic [plt_pkg::DATA_W-1:0]  read_data_i,
  input  logic [plt_pkg::CNT_W-1:0]   entry_count_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          list_size_o
);

  localparam int unsigned DEPTH = plt_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic                        ok;
    logic                        found;
    logic [plt_pkg::POS_W-1:0]   found_pos;
    logic [plt_pkg::KEY_W-1:0]   read_key;
    logic [plt_pkg::DATA_W-1:0]  read_data;
    logic [plt_pkg::CNT_W-1:0]   count;
  } list_result_t;

  // Shadow copy of the list; entries at and above list_len are never read
  logic [plt_pkg::KEY_W-1:0]   shadow_keys [DEPTH];
  logic [plt_pkg::DATA_W-1:0]  shadow_data [DEPTH];
  int unsigned                 list_len;
  list_result_t                awaited_results [$];
  int                          failures = 0;

  // Apply one command beat to the shadow list and return the result it must produce
  function automatic list_result_t apply_list_command(
    input logic [plt_pkg::CMD_W-1:0]   cmd,
    input logic [plt_pkg::POS_W-1:0]   pos_field,
    input logic                        app,
    input logic [plt_pkg::KEY_W-1:0]   key,
    input logic [plt_pkg::DATA_W-1:0]  data
  );
    list_result_t res;
    int unsigned  pos;
    int unsigned  i;
    res = '0;
    pos = pos_field;
    case (cmd)
      plt_pkg::CMD_CLEAR: begin
        list_len = 0;
        res.ok = 1'b1;
      end
      plt_pkg::CMD_INSERT: begin
        if (app) pos = list_len;
        if (list_len < DEPTH && pos <= list_len) begin
          for (i = list_len; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_data[i] = shadow_data[i-1];
          end
          shadow_keys[pos] = key;
          shadow_data[pos] = data;
          list_len++;
          res.ok = 1'b1;
        end
      end
      plt_pkg::CMD_DELETE: begin
        if (pos < list_len) begin
          for (i = pos; i + 1 < list_len; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_data[i] = shadow_data[i+1];
          end
          list_len--;
          res.ok = 1'b1;
        end
      end
      plt_pkg::CMD_READ: begin
        if (pos < list_len) begin
          res.read_key  = shadow_keys[pos];
          res.read_data = shadow_data[pos];
          res.ok = 1'b1;
        end
      end
      plt_pkg::CMD_UPDATE: begin
        if (pos < list_len) begin
          shadow_keys[pos] = key;
          shadow_data[pos] = data;
          res.ok = 1'b1;
        end
      end
      plt_pkg::CMD_FIND: begin
        res.ok = 1'b1;
        // first match wins
        for (i = 0; i < list_len; i++) begin
          if (!res.found && shadow_keys[i] == key) begin
            res.found     = 1'b1;
            res.found_pos = i[plt_pkg::POS_W-1:0];
          end
        end
      end
      default: ;  // spare codes leave the list alone
    endcase
    res.count = list_len[plt_pkg::CNT_W-1:0];
    return res;
  endfunction

  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    int           bad;
    if (!rst_ni) begin
      list_len = 0;
      awaited_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(apply_list_command(command_i, position_i, append_i,
                                                     item_key_i, item_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with no command waiting: ok=%0b found=%0b pos=%0d count=%0d",
                   $time, ok_i, found_i, found_position_i, entry_count_i);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          bad  = field_differs("ok", 64'(want.ok), 64'(ok_i))
               + field_differs("found", 64'(want.found), 64'(found_i))
               + field_differs("found_position", 64'(want.found_pos), 64'(found_position_i))
               + field_differs("read_key", want.read_key, read_key_i)
               + field_differs("read_data", 64'(want.read_data), 64'(read_data_i))
               + field_differs("entry_count", 64'(want.count), 64'(entry_count_i));
          if (bad != 0) failures++;
        end
      end
    end
    fail_count_o <= failures;
    pending_o    <= awaited_results.size();
    list_size_o  <= list_len;
  end

endmodule

[tb/sv/tb_positional_list_table.sv]
`timescale 1ns / 1ps

module tb_positional_list_table;

  localparam int unsigned CMD_W  = plt_pkg::CMD_W;
  localparam int unsigned POS_W  = plt_pkg::POS_W;
  localparam int unsigned KEY_W  = plt_pkg::KEY_W;
  localparam int unsigned DATA_W = plt_pkg::DATA_W;
  localparam int unsigned CNT_W  = plt_pkg::CNT_W;

  // Command codes the block has no use for; they must be answered with ok low
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int unsigned DRAIN_CYCLES    = 100;
  localparam int          PHASE_ITEMS     = 100;
  localparam int          KEY_POOL        = 8;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    command    = plt_pkg::CMD_CLEAR;
  logic [POS_W-1:0]    position   = '0;
  logic                append     = 1'b0;
  logic [KEY_W-1:0]    item_key   = '0;
  logic [DATA_W-1:0]   item_data  = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic                ok;
  logic                found;
  logic [POS_W-1:0]    found_position;
  logic [KEY_W-1:0]    read_key;
  logic [DATA_W-1:0]   read_data;
  logic [CNT_W-1:0]    entry_count;

  int                  failures;
  int                  pending;
  int                  list_size;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int unsigned         quiet_cycles   = 0;
  logic [KEY_W-1:0]    key_pool [KEY_POOL];

  positional_list_table dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (command),
    .position_i       (position),
    .append_i         (append),
    .item_key_i       (item_key),
    .item_data_i      (item_data),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .ok_o             (ok),
    .found_o          (found),
    .found_position_o (found_position),
    .read_key_o       (read_key),
    .read_data_o      (read_data),
    .entry_count_o    (entry_count)
  );

  plt_list_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .command_i        (command),
    .position_i       (position),
    .append_i         (append),
    .item_key_i       (item_key),
    .item_data_i      (item_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .ok_i             (ok),
    .found_i          (found),
    .found_position_i (found_position),
    .read_key_i       (read_key),
    .read_data_i      (read_data),
    .entry_count_i    (entry_count),
    .fail_count_o     (failures),
    .pending_o        (pending),
    .list_size_o      (list_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stall at the rate the current phase asks for
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Abort when neither channel moves a beat for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("positional_list_table test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command beat and hold it until the block takes it. Valid stays
  // high into the next beat unless an idle gap is drawn, so back-to-back beats
  // never see valid dropped and raised in the same step.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic app, input logic [KEY_W-1:0] key,
                              input logic [DATA_W-1:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    position  <= pos;
    append    <= app;
    item_key  <= key;
    item_data <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every result in flight has come back
  task automatic wait_list_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly keys from a small pool so finds hit and duplicates occur
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return {$urandom, $urandom};
  endfunction

  // Mostly positions inside or just past the list; list_size may trail by one beat
  function automatic logic [POS_W-1:0] pick_pos();
    int p;
    if ($urandom_range(0, 99) < 20) return POS_W'($urandom_range(0, 31));
    p = $urandom_range(0, list_size);
    if (p > 31) p = 31;
    return POS_W'(p);
  endfunction

  task automatic random_phase(input int items);
    int sent;
    int r;
    int i;
    int stop;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // fill toward capacity, then push against the full list
        stop = int'(plt_pkg::CAPACITY_DEF) + 2 - list_size;
        for (i = 0; i < stop; i++) begin
          if ($urandom_range(0, 1) == 1)
            send_command(plt_pkg::CMD_INSERT, POS_W'($urandom_range(0, 31)), 1'b1,
                         pick_key(), $urandom);
          else
            send_command(plt_pkg::CMD_INSERT, pick_pos(), 1'b0, pick_key(), $urandom);
          sent++;
        end
        send_command(plt_pkg::CMD_INSERT, '0, 1'b0, pick_key(), $urandom);
        sent++;
      end else if (r < 7) begin
        // drain from the front or the back
        stop = list_size + 1;
        for (i = 0; i < stop; i++) begin
          if ($urandom_range(0, 1) == 1 || list_size == 0)
            send_command(plt_pkg::CMD_DELETE, '0, 1'b0, pick_key(), $urandom);
          else
            send_command(plt_pkg::CMD_DELETE, POS_W'(list_size - 1), 1'b0, pick_key(),
                         $urandom);
          sent++;
        end
      end else begin
        if (r < 9)
          send_command(plt_pkg::CMD_CLEAR, POS_W'($urandom), 1'($urandom), pick_key(),
                       $urandom);
        else if (r < 11)
          send_command(($urandom_range(0, 1) == 1) ? CMD_SPARE_HI : CMD_SPARE_LO,
                       POS_W'($urandom), 1'($urandom), pick_key(), $urandom);
        else if (r < 45)
          send_command(plt_pkg::CMD_INSERT, pick_pos(), ($urandom_range(0, 3) == 0),
                       pick_key(), $urandom);
        else if (r < 60)
          send_command(plt_pkg::CMD_DELETE, pick_pos(), 1'($urandom), pick_key(), $urandom);
        else if (r < 75)
          send_command(plt_pkg::CMD_READ, pick_pos(), 1'($urandom), pick_key(), $urandom);
        else if (r < 85)
          send_command(plt_pkg::CMD_UPDATE, pick_pos(), 1'($urandom), pick_key(), $urandom);
        else
          send_command(plt_pkg::CMD_FIND, POS_W'($urandom), 1'($urandom), pick_key(),
                       $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    for (int k = 0; k < KEY_POOL; k++) key_pool[k] = {$urandom, $urandom};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: empty list, boundary positions, append, duplicates, spare codes
    send_command(plt_pkg::CMD_CLEAR,  '0,    1'b0, '0, '0);
    send_command(plt_pkg::CMD_READ,   '0,    1'b0, '0, '0);     // nothing to read
    send_command(plt_pkg::CMD_DELETE, '0,    1'b0, '0, '0);     // nothing to delete
    send_command(plt_pkg::CMD_UPDATE, '0,    1'b0, '1, '1);     // nothing to update
    send_command(plt_pkg::CMD_FIND,   '0,    1'b0, '0, '0);     // empty find, no match
    send_command(plt_pkg::CMD_INSERT, 5'd1,  1'b0, '1, '1);     // position past the end
    send_command(plt_pkg::CMD_INSERT, '0,    1'b0, '1, '1);
    send_command(plt_pkg::CMD_INSERT, '1,    1'b1, '0, '0);     // append ignores position
    send_command(plt_pkg::CMD_INSERT, 5'd1,  1'b0, {16{4'hA}}, {8{4'h5}});
    // position equal to count
    send_command(plt_pkg::CMD_INSERT, 5'd3,  1'b0, {16{4'h5}}, {8{4'hA}});
    // duplicate key
    send_command(plt_pkg::CMD_INSERT, 5'd20, 1'b1, {16{4'hA}}, 32'h1234_5678);
    send_command(plt_pkg::CMD_FIND,   '1,    1'b1, {16{4'hA}}, '0);  // first of two matches
    send_command(plt_pkg::CMD_FIND,   '0,    1'b0, '0, '0);
    send_command(plt_pkg::CMD_FIND,   '0,    1'b0, 64'h1, '0);  // no match
    send_command(plt_pkg::CMD_READ,   '0,    1'b0, '0, '0);
    send_command(plt_pkg::CMD_READ,   5'd4,  1'b0, '0, '0);
    send_command(plt_pkg::CMD_READ,   5'd5,  1'b0, '0, '0);     // one past the last entry
    send_command(plt_pkg::CMD_READ,   '1,    1'b1, '1, '1);
    send_command(plt_pkg::CMD_UPDATE, 5'd2,  1'b0, {16{4'h3}}, {8{4'hC}});
    send_command(plt_pkg::CMD_UPDATE, '1,    1'b0, '1, '1);
    send_command(plt_pkg::CMD_DELETE, 5'd1,  1'b0, '0, '0);     // middle entry
    send_command(plt_pkg::CMD_DELETE, 5'd3,  1'b0, '0, '0);     // last entry
    send_command(plt_pkg::CMD_DELETE, 5'd3,  1'b0, '0, '0);     // now past the end
    send_command(CMD_SPARE_LO, POS_W'($urandom), 1'($urandom), {$urandom, $urandom}, $urandom);
    send_command(CMD_SPARE_HI, '1,   1'b1, '1, '1);
    send_command(plt_pkg::CMD_CLEAR,  '1,    1'b1, '1, '1);
    send_command(plt_pkg::CMD_READ,   '0,    1'b0, '0, '0);     // cleared list reads nothing

    // Random beats, one phase per handshake pressure setting
    random_phase(PHASE_ITEMS);

    send_idle_pct  = 88;
    recv_stall_pct = 0;
    random_phase(PHASE_ITEMS);

    // Let the block run dry before the receiver starts stalling
    wait_list_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    random_phase(PHASE_ITEMS);

    send_idle_pct  = 6;
    recv_stall_pct = 6;
    random_phase(PHASE_ITEMS);

    // Drain: all results back, then watch a while for strays
    wait_list_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("positional_list_table test passed");
    end else begin
      $display("positional_list_table test failed");
    end
    $finish;
  end

endmodule
